>>> src/lcdmt_pkg.sv
// Shared types and timing constants for the LCD mode timing sequencer.
package lcdmt_pkg;

	// Frame and line timing, in machine cycles and lines
	localparam int unsigned FRAME_CYCLES  = 70224;
	localparam int unsigned SCAN_CYCLES   = 80;
	localparam int unsigned DRAW_CYCLES   = 172;
	localparam int unsigned LINE_CYCLES   = 456;
	localparam int unsigned VISIBLE_LINES = 144;
	localparam int unsigned TOTAL_LINES   = 154;

	// Widths of the cycle count and of its running remainder per line
	localparam int unsigned COUNT_W = 17;
	localparam int unsigned REM_W   = $clog2(LINE_CYCLES);

	// Configuration port widths
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned CFG_IDX_W  = 3;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COMPARE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COIN_IRQ_EN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HBLANK_IRQ_EN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VBLANK_IRQ_EN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OAM_IRQ_EN    = 3'd4;

	typedef struct packed {
		logic [7:0] line_compare;
		logic       coincidence_irq_enable;
		logic       hblank_irq_enable;
		logic       vblank_stat_irq_enable;
		logic       oam_irq_enable;
	} cfg_t;

	typedef struct packed {
		logic [1:0] status_mode;
		logic [7:0] line_number;
		logic       coincidence;
		logic       vblank_irq;
		logic       stat_irq;
		logic       stat_irq_clear;
		logic       redisplay;
		logic       scan_sprites_now;
		logic       render_line_now;
	} result_t;

endpackage

>>> src/lcdmt_tick_if.sv
// Input channel of the sequencer: one tick word per handshake.
interface lcdmt_tick_if;
	logic       valid;
	logic       ready;
	logic [7:0] elapsed_cycles;
	logic       display_enable;

	modport source (output valid, output elapsed_cycles, output display_enable, input ready);
	modport sink (input valid, input elapsed_cycles, input display_enable, output ready);
endinterface

>>> src/lcdmt_result_if.sv
// Result channel of the sequencer: one status word per handshake.
interface lcdmt_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] status_mode;
	logic [7:0] line_number;
	logic       coincidence;
	logic       vblank_irq;
	logic       stat_irq;
	logic       stat_irq_clear;
	logic       redisplay;
	logic       scan_sprites_now;
	logic       render_line_now;

	modport source (
		output valid, output status_mode, output line_number, output coincidence,
		output vblank_irq, output stat_irq, output stat_irq_clear, output redisplay,
		output scan_sprites_now, output render_line_now, input ready
	);
	modport sink (
		input valid, input status_mode, input line_number, input coincidence,
		input vblank_irq, input stat_irq, input stat_irq_clear, input redisplay,
		input scan_sprites_now, input render_line_now, output ready
	);
endinterface

>>> src/lcdmt_cfg_regs.sv
// Configuration registers: compare line and status interrupt selects.
module lcdmt_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lcdmt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lcdmt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output lcdmt_pkg::cfg_t                     cfg
);

	lcdmt_pkg::cfg_t cfg_q;

	// Take a write into the addressed register; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lcdmt_pkg::REG_LINE_COMPARE:  cfg_q.line_compare <= cfg_wdata[7:0];
				lcdmt_pkg::REG_COIN_IRQ_EN:   cfg_q.coincidence_irq_enable <= cfg_wdata[0];
				lcdmt_pkg::REG_HBLANK_IRQ_EN: cfg_q.hblank_irq_enable <= cfg_wdata[0];
				lcdmt_pkg::REG_VBLANK_IRQ_EN: cfg_q.vblank_stat_irq_enable <= cfg_wdata[0];
				lcdmt_pkg::REG_OAM_IRQ_EN:    cfg_q.oam_irq_enable <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/lcdmt_step.sv
// Mode sequencer state and the next-state logic for one tick.
module lcdmt_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic [7:0]           elapsed_cycles,
	input  logic                 display_enable,
	input  lcdmt_pkg::cfg_t      cfg,
	output lcdmt_pkg::result_t   res
);

	localparam int unsigned CW = lcdmt_pkg::COUNT_W;
	localparam int unsigned RW = lcdmt_pkg::REM_W;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_SCAN   = 2'd2,
		MODE_DRAW   = 2'd3
	} mode_t;

	logic [CW-1:0] count_q, count_n;
	logic [RW-1:0] rem_q, rem_n;
	mode_t         mode_q, mode_n;
	mode_t         shown_q, shown_n;
	logic [7:0]    line_q, line_n;
	logic          was_en_q;
	logic          match_q, match_n;

	logic [CW:0]   sum;
	logic          wrap;
	logic [RW:0]   rem_sum;
	logic [RW:0]   rem_red;
	logic [CW-1:0] count_acc;
	logic [RW-1:0] rem_acc;
	logic [7:0]    line_inc;
	logic          inc_match;
	logic          zero_match;
	logic          vblank_ev, stat_ev, clear_ev, redisplay_ev, scan_ev, render_ev;

	// Accumulate cycles; keep the remainder per line alongside the count
	always_comb begin
		sum       = {1'b0, count_q} + (CW+1)'(elapsed_cycles);
		wrap      = sum >= (CW+1)'(lcdmt_pkg::FRAME_CYCLES);
		rem_sum   = {1'b0, rem_q} + (RW+1)'(elapsed_cycles);
		rem_red   = (rem_sum >= (RW+1)'(lcdmt_pkg::LINE_CYCLES))
			? rem_sum - (RW+1)'(lcdmt_pkg::LINE_CYCLES) : rem_sum;
		count_acc = wrap ? '0 : sum[CW-1:0];
		rem_acc   = wrap ? '0 : rem_red[RW-1:0];
		line_inc   = line_q + 8'd1;
		inc_match  = line_inc == cfg.line_compare;
		zero_match = cfg.line_compare == 8'd0;
	end

	// Advance the mode by at most one step
	always_comb begin
		count_n      = count_acc;
		rem_n        = rem_acc;
		mode_n       = mode_q;
		shown_n      = shown_q;
		line_n       = line_q;
		match_n      = match_q;
		vblank_ev    = 1'b0;
		stat_ev      = 1'b0;
		clear_ev     = 1'b0;
		redisplay_ev = wrap || (display_enable != was_en_q);
		scan_ev      = 1'b0;
		render_ev    = 1'b0;

		if (!display_enable) begin
			// Display switched off: drop back to line 0 and cancel requests
			if (was_en_q) begin
				clear_ev = 1'b1;
				count_n  = '0;
				rem_n    = '0;
				mode_n   = MODE_SCAN;
				shown_n  = MODE_HBLANK;
				line_n   = 8'd0;
				match_n  = 1'b0;
			end
		end else begin
			case (mode_q)
				MODE_SCAN: begin
					if (count_acc >= CW'(lcdmt_pkg::SCAN_CYCLES)) begin
						scan_ev = 1'b1;
						mode_n  = MODE_DRAW;
						shown_n = MODE_DRAW;
					end
				end
				MODE_DRAW: begin
					if (count_acc >= CW'(lcdmt_pkg::SCAN_CYCLES + lcdmt_pkg::DRAW_CYCLES)) begin
						render_ev = 1'b1;
						mode_n    = MODE_HBLANK;
						shown_n   = MODE_HBLANK;
						stat_ev   = cfg.hblank_irq_enable;
					end
				end
				MODE_HBLANK: begin
					if (count_acc >= CW'(lcdmt_pkg::LINE_CYCLES)) begin
						count_n = CW'(rem_acc);
						line_n  = line_inc;
						match_n = inc_match;
						if (line_inc >= 8'(lcdmt_pkg::VISIBLE_LINES)) begin
							mode_n       = MODE_VBLANK;
							shown_n      = MODE_VBLANK;
							vblank_ev    = 1'b1;
							redisplay_ev = 1'b1;
							stat_ev      = (cfg.coincidence_irq_enable && inc_match)
								|| cfg.vblank_stat_irq_enable;
						end else begin
							mode_n  = MODE_SCAN;
							shown_n = MODE_SCAN;
							stat_ev = (cfg.coincidence_irq_enable && inc_match)
								|| cfg.oam_irq_enable;
						end
					end
				end
				MODE_VBLANK: begin
					if (count_acc >= CW'(lcdmt_pkg::LINE_CYCLES)) begin
						count_n = CW'(rem_acc);
						line_n  = line_inc;
						match_n = inc_match;
						stat_ev = cfg.coincidence_irq_enable && inc_match;
						// Frame end: wrap to line 0 and start the next OAM scan
						if (line_inc >= 8'(lcdmt_pkg::TOTAL_LINES)) begin
							line_n  = 8'd0;
							match_n = zero_match;
							mode_n  = MODE_SCAN;
							shown_n = MODE_SCAN;
							stat_ev = (cfg.coincidence_irq_enable && (inc_match || zero_match))
								|| cfg.oam_irq_enable;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Hold state between ticks; commit on each processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rem_q    <= '0;
			mode_q   <= MODE_SCAN;
			shown_q  <= MODE_HBLANK;
			line_q   <= 8'd0;
			was_en_q <= 1'b0;
			match_q  <= 1'b0;
		end else if (step_en) begin
			count_q  <= count_n;
			rem_q    <= rem_n;
			mode_q   <= mode_n;
			shown_q  <= shown_n;
			line_q   <= line_n;
			was_en_q <= display_enable;
			match_q  <= match_n;
		end
	end

	// Result word of this tick
	always_comb begin
		res.status_mode      = shown_n;
		res.line_number      = line_n;
		res.coincidence      = match_n;
		res.vblank_irq       = vblank_ev;
		res.stat_irq         = stat_ev;
		res.stat_irq_clear   = clear_ev;
		res.redisplay        = redisplay_ev;
		res.scan_sprites_now = scan_ev;
		res.render_line_now  = render_ev;
	end

endmodule

>>> src/lcd_mode_timing_sequencer_unit.sv
// LCD mode timing sequencer: top level with input and result registers.
//
// Usage: each tick word on the tick channel carries the machine cycles since
// the previous tick and the display enable bit. For every accepted tick the
// block returns exactly one status word on the result channel: shown mode,
// line counter, coincidence flag and the event pulses of that tick.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes the compare
// line and the four status interrupt selects; write it only while no tick
// is in flight. Indexes beyond the register list are ignored.
// Path: the status word is formed from its tick in the input register and
// then held in the result register. Throughput: one tick per cycle while
// the receiver takes the results; the sequencer state updates as a word
// moves from the input register into the result register.
// Reset (arst_n low) empties both registers and returns the sequencer to
// line 0, OAM scan, count 0, display seen as off; config registers clear.
// When the receiver stalls, the result register holds its word and one more
// tick waits in the input register; tick.ready falls only when both are full.
module lcd_mode_timing_sequencer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	lcdmt_tick_if.sink                        tick,
	lcdmt_result_if.source                    result,
	input  logic                              cfg_we,
	input  logic [lcdmt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lcdmt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	lcdmt_pkg::cfg_t    cfg;
	lcdmt_pkg::result_t res;
	lcdmt_pkg::result_t res_q;

	logic       valid_s1;
	logic [7:0] elapsed_s1;
	logic       enable_s1;
	logic       out_valid_q;
	logic       advance;

	lcdmt_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lcdmt_step u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (valid_s1 && advance),
		.elapsed_cycles (elapsed_s1),
		.display_enable (enable_s1),
		.cfg            (cfg),
		.res            (res)
	);

	// Move a word on when the result register is free or being drained
	assign advance    = !out_valid_q || result.ready;
	assign tick.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			elapsed_s1 <= tick.elapsed_cycles;
			enable_s1  <= tick.display_enable;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q <= res;
		end
	end

	// Drive the result channel
	assign result.valid            = out_valid_q;
	assign result.status_mode      = res_q.status_mode;
	assign result.line_number      = res_q.line_number;
	assign result.coincidence      = res_q.coincidence;
	assign result.vblank_irq       = res_q.vblank_irq;
	assign result.stat_irq         = res_q.stat_irq;
	assign result.stat_irq_clear   = res_q.stat_irq_clear;
	assign result.redisplay        = res_q.redisplay;
	assign result.scan_sprites_now = res_q.scan_sprites_now;
	assign result.render_line_now  = res_q.render_line_now;

endmodule

>>> verif/lcd_mode_timing_sequencer_unit_tb.sv
// Self-checking testbench for the LCD mode timing sequencer unit.
`timescale 1ns / 1ps

module lcd_mode_timing_sequencer_unit_tb;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 5;
	localparam int QUIET_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 400;

	localparam int unsigned IDX_W  = lcdmt_pkg::CFG_IDX_W;
	localparam int unsigned DATA_W = lcdmt_pkg::CFG_DATA_W;

	// Indexes past the register list
	localparam int                   REG_UNUSED_FIRST = 5;
	localparam int                   REG_UNUSED_LAST  = 7;

	typedef enum logic [1:0] {
		MODE_HBLANK   = 2'd0,
		MODE_VBLANK   = 2'd1,
		MODE_OAM_SCAN = 2'd2,
		MODE_DRAWING  = 2'd3
	} lcd_mode_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [DATA_W-1:0] cfg_wdata;

	lcdmt_tick_if   tick_ch ();
	lcdmt_result_if res_ch ();

	lcd_mode_timing_sequencer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Sequencer state mirrored by the predictor
	lcdmt_pkg::cfg_t seq_cfg    = '0;
	logic [16:0] seq_count      = '0;
	lcd_mode_t   seq_mode       = MODE_OAM_SCAN;
	lcd_mode_t   seq_shown      = MODE_HBLANK;
	logic [7:0]  seq_line       = '0;
	logic        seq_enabled    = 1'b0;
	logic        seq_match      = 1'b0;
	logic        pend_vblank;
	logic        pend_stat;
	logic        pend_redisplay;

	lcdmt_pkg::result_t status_q[$];
	lcdmt_pkg::result_t status_want;
	int          mismatches  = 0;
	int          quiet       = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          hold_len    = 0;
	int          run_left    = 0;
	bit          run_on      = 1'b0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Load the line counter and refresh the coincidence flag
	function automatic void take_line(input logic [7:0] line);
		seq_line  = line;
		seq_match = (seq_line == seq_cfg.line_compare);
		if (seq_cfg.coincidence_irq_enable && seq_match)
			pend_stat = 1'b1;
	endfunction

	// Enter a mode and raise the requests tied to it
	function automatic void switch_mode(input lcd_mode_t mode);
		seq_mode  = mode;
		seq_shown = mode;
		case (mode)
			MODE_HBLANK: begin
				if (seq_cfg.hblank_irq_enable)
					pend_stat = 1'b1;
			end
			MODE_VBLANK: begin
				pend_redisplay = 1'b1;
				pend_vblank    = 1'b1;
				if (seq_cfg.vblank_stat_irq_enable)
					pend_stat = 1'b1;
			end
			MODE_OAM_SCAN: begin
				if (seq_cfg.oam_irq_enable)
					pend_stat = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// Advance the mirrored sequencer by one tick and form its status word
	function automatic lcdmt_pkg::result_t advance_sequencer(input logic [7:0] elapsed,
			input logic enable);
		int unsigned        total;
		lcdmt_pkg::result_t r;
		logic               cleared;
		logic               scanned;
		logic               rendered;

		pend_vblank    = 1'b0;
		pend_stat      = 1'b0;
		pend_redisplay = 1'b0;
		cleared        = 1'b0;
		scanned        = 1'b0;
		rendered       = 1'b0;

		total = seq_count + elapsed;
		if (total >= lcdmt_pkg::FRAME_CYCLES) begin
			pend_redisplay = 1'b1;
			total = 0;
		end
		seq_count = total[16:0];

		if (enable != seq_enabled) begin
			seq_enabled    = enable;
			pend_redisplay = 1'b1;
			// Display off: back to line 0, scan pending, status request dropped
			if (!enable) begin
				seq_line  = '0;
				seq_match = 1'b0;
				pend_stat = 1'b0;
				cleared   = 1'b1;
				seq_count = '0;
				seq_mode  = MODE_OAM_SCAN;
				seq_shown = MODE_HBLANK;
			end
		end

		// At most one mode step per tick
		if (enable) begin
			case (seq_mode)
				MODE_OAM_SCAN: begin
					if (seq_count >= lcdmt_pkg::SCAN_CYCLES) begin
						scanned = 1'b1;
						switch_mode(MODE_DRAWING);
					end
				end
				MODE_DRAWING: begin
					if (seq_count >= lcdmt_pkg::SCAN_CYCLES + lcdmt_pkg::DRAW_CYCLES) begin
						rendered = 1'b1;
						switch_mode(MODE_HBLANK);
					end
				end
				MODE_HBLANK: begin
					if (seq_count >= lcdmt_pkg::LINE_CYCLES) begin
						seq_count = 17'(seq_count % lcdmt_pkg::LINE_CYCLES);
						take_line(8'(seq_line + 8'd1));
						if (seq_line >= lcdmt_pkg::VISIBLE_LINES)
							switch_mode(MODE_VBLANK);
						else
							switch_mode(MODE_OAM_SCAN);
					end
				end
				default: begin
					if (seq_count >= lcdmt_pkg::LINE_CYCLES) begin
						seq_count = 17'(seq_count % lcdmt_pkg::LINE_CYCLES);
						take_line(8'(seq_line + 8'd1));
						if (seq_line >= lcdmt_pkg::TOTAL_LINES) begin
							take_line(8'd0);
							switch_mode(MODE_OAM_SCAN);
						end
					end
				end
			endcase
		end

		r.status_mode      = seq_shown;
		r.line_number      = seq_line;
		r.coincidence      = seq_match;
		r.vblank_irq       = pend_vblank;
		r.stat_irq         = pend_stat;
		r.stat_irq_clear   = cleared;
		r.redisplay        = pend_redisplay;
		r.scan_sprites_now = scanned;
		r.render_line_now  = rendered;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Compare each accepted status word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (status_q.size() == 0) begin
				$error("status word arrived with no tick outstanding");
				mismatches++;
			end else begin
				status_want = status_q.pop_front();
				check_field("status_mode", 8'(status_want.status_mode), 8'(res_ch.status_mode));
				check_field("line_number", status_want.line_number, res_ch.line_number);
				check_field("coincidence", 8'(status_want.coincidence), 8'(res_ch.coincidence));
				check_field("vblank_irq", 8'(status_want.vblank_irq), 8'(res_ch.vblank_irq));
				check_field("stat_irq", 8'(status_want.stat_irq), 8'(res_ch.stat_irq));
				check_field("stat_irq_clear", 8'(status_want.stat_irq_clear),
					8'(res_ch.stat_irq_clear));
				check_field("redisplay", 8'(status_want.redisplay), 8'(res_ch.redisplay));
				check_field("scan_sprites_now", 8'(status_want.scan_sprites_now),
					8'(res_ch.scan_sprites_now));
				check_field("render_line_now", 8'(status_want.render_line_now),
					8'(res_ch.render_line_now));
			end
		end
	end

	// Drop the run if no word moves on either channel for too long
	always @(posedge clk) begin
		if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Offer one tick word, idling first at random, and predict its status
	task automatic send_tick(input logic [7:0] elapsed, input logic enable);
		while ($urandom_range(99) < tx_idle_pct) begin
			tick_ch.valid          <= 1'b0;
			tick_ch.elapsed_cycles <= 8'($urandom);
			tick_ch.display_enable <= 1'($urandom);
			@(posedge clk);
		end
		tick_ch.valid          <= 1'b1;
		tick_ch.elapsed_cycles <= elapsed;
		tick_ch.display_enable <= enable;
		do @(posedge clk); while (!tick_ch.ready);
		status_q.push_back(advance_sequencer(elapsed, enable));
	endtask

	// Drop valid, wait for every outstanding word, then let the pipe settle
	task automatic wait_idle();
		tick_ch.valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			lcdmt_pkg::REG_LINE_COMPARE:  seq_cfg.line_compare           = data;
			lcdmt_pkg::REG_COIN_IRQ_EN:   seq_cfg.coincidence_irq_enable = data[0];
			lcdmt_pkg::REG_HBLANK_IRQ_EN: seq_cfg.hblank_irq_enable      = data[0];
			lcdmt_pkg::REG_VBLANK_IRQ_EN: seq_cfg.vblank_stat_irq_enable = data[0];
			lcdmt_pkg::REG_OAM_IRQ_EN:    seq_cfg.oam_irq_enable         = data[0];
			default: ;
		endcase
	endtask

	// Write every register (junk in the upper bits of the selects),
	// then poke the unused indexes, which must change nothing
	task automatic set_config(input logic [7:0] lyc, input logic [3:0] sel);
		write_reg(lcdmt_pkg::REG_LINE_COMPARE, lyc);
		write_reg(lcdmt_pkg::REG_COIN_IRQ_EN, {7'($urandom), sel[3]});
		write_reg(lcdmt_pkg::REG_HBLANK_IRQ_EN, {7'($urandom), sel[2]});
		write_reg(lcdmt_pkg::REG_VBLANK_IRQ_EN, {7'($urandom), sel[1]});
		write_reg(lcdmt_pkg::REG_OAM_IRQ_EN, {7'($urandom), sel[0]});
		for (int i = REG_UNUSED_FIRST; i <= REG_UNUSED_LAST; i++)
			write_reg(IDX_W'(i), 8'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Elapsed counts skewed large so that frames complete in a few hundred ticks
	function automatic logic [7:0] pick_elapsed();
		int unsigned r;

		r = $urandom_range(99);
		if (r < 8)
			return 8'd0;
		else if (r < 16)
			return 8'd255;
		else if (r < 40)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(128, 255));
	endfunction

	// Hand-picked ticks: extremes, the scan, draw and hblank steps, display on/off
	task automatic test_directed();
		logic [7:0] elapsed_seq[22] = '{0, 255, 0, 0, 200, 1, 79, 1, 171, 1, 10,
			0, 255, 255, 255, 255, 255, 0, 255, 255, 128, 255};
		logic       enable_seq[22]  = '{0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 0,
			0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0};

		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		set_config(8'd1, 4'b1111);
		foreach (elapsed_seq[i])
			send_tick(elapsed_seq[i], enable_seq[i]);
	endtask

	// Runs of enabled ticks long enough to pass through whole frames, with
	// short runs and brief display-off bursts mixed in
	task automatic test_frame_sequences(input int tx_pct, input int rx_pct,
			input logic [7:0] lyc, input logic [3:0] sel, input int count);
		wait_idle();
		set_config(lyc, sel);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (count) begin
			if (run_left == 0) begin
				run_on = !run_on;
				if (!run_on)
					run_left = $urandom_range(1, 4);
				else if ($urandom_range(99) < 75)
					run_left = $urandom_range(480, 700);
				else
					run_left = $urandom_range(5, 60);
			end
			send_tick(pick_elapsed(), run_on);
			run_left--;
		end
	endtask

	// Keep the display off long enough for the cycle count to wrap a frame
	task automatic test_blank_frame_wrap();
		wait_idle();
		set_config(8'($urandom), 4'($urandom));
		tx_idle_pct  = 13;
		rx_stall_pct = 13;
		repeat (300)
			send_tick(8'($urandom_range(240, 255)), 1'b0);
		run_on   = 1'b0;
		run_left = 0;
	endtask

	// Hold off the receiver while ticks keep coming, so the block fills up
	task automatic test_stall_fill();
		wait_idle();
		tx_idle_pct  = 0;
		rx_stall_pct = 13;
		hold_len     = HOLD_CYCLES;
		repeat (30)
			send_tick(pick_elapsed(), 1'b1);
	endtask

	initial begin
		tick_ch.valid          = 1'b0;
		tick_ch.elapsed_cycles = '0;
		tick_ch.display_enable = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = '0;
		cfg_wdata              = '0;
		arst_n                 = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_frame_sequences(0, 0, 8'd153, 4'b1111, 340);
		test_frame_sequences(53, 0, 8'd255, 4'b0000, 340);
		test_frame_sequences(0, 53, 8'($urandom_range(0, 153)), 4'($urandom), 340);
		test_frame_sequences(13, 13, 8'd144, 4'($urandom), 340);
		test_blank_frame_wrap();
		test_stall_fill();
		wait_idle();

		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
